/* hw/rtl/fhi_pkg.sv */
// Package for the fingerprint hash index unit: status codes, sequencer states, key word count.
// No dependencies; used by fingerprint_hash_index_unit and its checker.
package fhi_pkg;

  localparam int unsigned KeyWords = 4;

  // Result status codes.
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StFill,
    StScan,
    StAddr,
    StWrite,
    StDone,
    StClear
  } state_e;

endpackage

/* hw/rtl/fingerprint_hash_index_unit.sv */
// Top level of the fingerprint hash index unit: bucket hash, restoring modulo unit,
// bucket fill counters, key and address memories and the scan sequencer. Uses fhi_pkg.

// One request is taken at a time. After reset the block clears the bucket fill counters
// and is not ready meanwhile. The bucket index is the XOR of the four key words reduced
// modulo buckets_in_use by a restoring divider that retires one quotient bit per cycle,
// followed by a read of the bucket's fill count. A lookup then reads the key memory one
// word at a time (read, then compare) over the entries of the bucket, and fetches the
// address on a hit; an insert writes the four key words and the address unless the bucket
// is full. A final done state sets the valid flag of the output register. The result
// waits in the output register, and no new request is taken until it has been accepted.
module fingerprint_hash_index_unit #(
  parameter int unsigned MAX_BUCKETS        = 1024,
  parameter int unsigned ENTRIES_PER_BUCKET = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: buckets_in_use.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [10:0]  cfg_data_i,
  // Request stream.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: key_word0 [63:0], key_word1 [127:64], key_word2 [191:128],
  //        key_word3 [255:192], entry_address [319:256]
  input  logic [319:0] s_axis_tdata_i,
  // tuser: action [0]
  input  logic         s_axis_tuser_i,
  // Result stream.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: status [1:0], found_address [65:2], bucket_index [75:66], zero [79:76]
  output logic [79:0]  m_axis_tdata_o
);

  localparam int unsigned BW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned EW   = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;
  localparam int unsigned FW   = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int unsigned SlotW = BW + EW;
  localparam int unsigned KeyAw = SlotW + 2;
  localparam int unsigned NW   = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned RW   = NW + 1;

  // State.
  fhi_pkg::state_e state_q, state_d;
  logic [10:0]  buckets_q;
  logic         action_q;
  logic [63:0]  key_q [fhi_pkg::KeyWords];
  logic [63:0]  entry_addr_q;
  logic [63:0]  dividend_q;
  logic [RW-1:0] rem_q;
  logic [NW-1:0] divisor_q;
  logic [6:0]   bitcnt_q;
  logic [BW-1:0] bucket_q;
  logic [BW-1:0] clr_q;
  logic [FW-1:0] fill_q;
  logic [EW-1:0] slot_q;
  logic [FW-1:0] scanned_q;
  logic [1:0]   word_q;
  logic         match_q;
  logic         rd_pend_q;
  logic [1:0]   status_q;
  logic [63:0]  addr_out_q;
  logic         out_valid_q;

  // Memories.
  logic [63:0]  key_mem  [2**KeyAw];
  logic [63:0]  addr_mem [2**SlotW];
  logic [FW-1:0] fill_mem [MAX_BUCKETS];
  logic [63:0]  key_rd_q, addr_rd_q;
  logic [FW-1:0] fill_rd_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == fhi_pkg::StIdle) && !out_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, 10'(bucket_q), addr_out_q, status_q};

  logic in_fire;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // Clamp the configured bucket count to 1..MAX_BUCKETS.
  logic [NW-1:0] n_eff;
  always_comb begin
    if (buckets_q == 11'd0) begin
      n_eff = NW'(1);
    end else if (32'(buckets_q) > MAX_BUCKETS) begin
      n_eff = NW'(MAX_BUCKETS);
    end else begin
      n_eff = NW'(buckets_q);
    end
  end

  // Restoring divider step: shift in one dividend bit, subtract if possible.
  logic [RW-1:0] rem_shift;
  logic          rem_ge;
  assign rem_shift = {rem_q[RW-2:0], dividend_q[63]};
  assign rem_ge    = rem_shift >= RW'(divisor_q);

  // Key memory address for scan or write.
  logic [SlotW-1:0] slot_addr;
  logic [KeyAw-1:0] key_addr;
  assign slot_addr = {bucket_q, slot_q};
  assign key_addr  = {slot_addr, word_q};

  logic scan_last_word;
  assign scan_last_word = (word_q == 2'd3);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fhi_pkg::StClear: if (clr_q == BW'(MAX_BUCKETS - 1)) state_d = fhi_pkg::StIdle;
      fhi_pkg::StIdle:  if (in_fire) state_d = fhi_pkg::StMod;
      fhi_pkg::StMod:   if (bitcnt_q == 7'd63) state_d = fhi_pkg::StFill;
      fhi_pkg::StFill:  begin
        if (rd_pend_q) begin
          if (action_q) begin
            state_d = (fill_rd_q >= FW'(ENTRIES_PER_BUCKET)) ? fhi_pkg::StDone
                                                              : fhi_pkg::StWrite;
          end else begin
            state_d = (fill_rd_q == '0) ? fhi_pkg::StDone : fhi_pkg::StScan;
          end
        end
      end
      fhi_pkg::StScan:  begin
        if (rd_pend_q && scan_last_word && match_q && (key_rd_q == key_q[3])) begin
          state_d = fhi_pkg::StAddr;
        end else if (rd_pend_q && scan_last_word && (scanned_q + FW'(1) == fill_q)) begin
          state_d = fhi_pkg::StDone;
        end
      end
      fhi_pkg::StAddr:  if (rd_pend_q) state_d = fhi_pkg::StDone;
      fhi_pkg::StWrite: if (word_q == 2'd3 && rd_pend_q) state_d = fhi_pkg::StDone;
      fhi_pkg::StDone:  state_d = fhi_pkg::StIdle;
      default:          state_d = fhi_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fhi_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buckets_q   <= 11'd1024;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      bitcnt_q    <= '0;
      clr_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        buckets_q <= cfg_data_i;
      end
      if (state_q == fhi_pkg::StDone) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      bitcnt_q  <= (state_q == fhi_pkg::StMod) ? bitcnt_q + 7'd1 : '0;
      if (state_q == fhi_pkg::StClear) begin
        clr_q <= clr_q + BW'(1);
      end
      // Memory reads are registered; toggle a pending flag around each word.
      case (state_q)
        fhi_pkg::StFill, fhi_pkg::StAddr: rd_pend_q <= ~rd_pend_q;
        fhi_pkg::StScan:  rd_pend_q <= (state_d == fhi_pkg::StScan) && !rd_pend_q;
        fhi_pkg::StWrite: rd_pend_q <= (word_q == 2'd3) ? ~rd_pend_q : 1'b0;
        default:          rd_pend_q <= 1'b0;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      fhi_pkg::StIdle: begin
        if (in_fire) begin
          action_q     <= s_axis_tuser_i;
          key_q[0]     <= s_axis_tdata_i[63:0];
          key_q[1]     <= s_axis_tdata_i[127:64];
          key_q[2]     <= s_axis_tdata_i[191:128];
          key_q[3]     <= s_axis_tdata_i[255:192];
          entry_addr_q <= s_axis_tdata_i[319:256];
          dividend_q   <= s_axis_tdata_i[63:0] ^ s_axis_tdata_i[127:64]
                        ^ s_axis_tdata_i[191:128] ^ s_axis_tdata_i[255:192];
          rem_q        <= '0;
          divisor_q    <= n_eff;
        end
      end
      fhi_pkg::StMod: begin
        dividend_q <= {dividend_q[62:0], 1'b0};
        rem_q      <= rem_ge ? rem_shift - RW'(divisor_q) : rem_shift;
        if (bitcnt_q == 7'd63) begin
          bucket_q <= rem_ge ? BW'(rem_shift - RW'(divisor_q)) : BW'(rem_shift);
        end
        status_q   <= fhi_pkg::StMiss;
        addr_out_q <= '0;
        slot_q     <= '0;
        word_q     <= '0;
        scanned_q  <= '0;
        match_q    <= 1'b1;
      end
      fhi_pkg::StFill: begin
        if (rd_pend_q) begin
          fill_q <= fill_rd_q;
          slot_q <= action_q ? EW'(fill_rd_q) : '0;
          if (action_q) begin
            status_q <= (fill_rd_q >= FW'(ENTRIES_PER_BUCKET)) ? fhi_pkg::StFull
                                                                : fhi_pkg::StOk;
          end
        end
      end
      fhi_pkg::StScan: begin
        if (rd_pend_q) begin
          if (scan_last_word) begin
            if (match_q && key_rd_q == key_q[3]) begin
              status_q <= fhi_pkg::StOk;
            end else begin
              slot_q    <= slot_q + EW'(1);
              scanned_q <= scanned_q + FW'(1);
              match_q   <= 1'b1;
            end
            word_q <= '0;
          end else begin
            match_q <= match_q && (key_rd_q == key_q[word_q]);
            word_q  <= word_q + 2'd1;
          end
        end
      end
      fhi_pkg::StAddr: begin
        if (rd_pend_q) addr_out_q <= addr_rd_q;
      end
      fhi_pkg::StWrite: begin
        if (word_q != 2'd3) word_q <= word_q + 2'd1;
      end
      default: ;
    endcase
  end

  // Fill counter write port: the clearing pass after reset, or an insert.
  logic          fill_we;
  logic [BW-1:0] fill_wa;
  logic [FW-1:0] fill_wd;
  always_comb begin
    fill_we = 1'b0;
    fill_wa = bucket_q;
    fill_wd = fill_q + FW'(1);
    if (state_q == fhi_pkg::StClear) begin
      fill_we = 1'b1;
      fill_wa = clr_q;
      fill_wd = '0;
    end else if (state_q == fhi_pkg::StWrite && word_q == 2'd3 && !rd_pend_q) begin
      fill_we = 1'b1;
    end
  end

  // Memories: fill counts, keys and addresses.
  always_ff @(posedge clk_i) begin
    fill_rd_q <= fill_mem[bucket_q];
    key_rd_q  <= key_mem[key_addr];
    addr_rd_q <= addr_mem[slot_addr];
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    if (state_q == fhi_pkg::StWrite) begin
      key_mem[key_addr] <= key_q[word_q];
      if (word_q == 2'd3 && !rd_pend_q) begin
        addr_mem[slot_addr] <= entry_addr_q;
      end
    end
  end

endmodule

/* hw/rtl/fhi_checker.sv */
// Port-level checker for fingerprint_hash_index_unit, bound to the top level.
// Uses fhi_pkg status codes.
module fhi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Status is never an unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3)
    else $error("bad status code");

  // Only a lookup hit carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != fhi_pkg::StOk |-> m_axis_tdata_o[65:2] == '0)
    else $error("address on a miss or full");

  // No new request taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("ready with pending result");

  // A request cannot produce a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !m_axis_tvalid_o)
    else $error("result too early");

endmodule

bind fingerprint_hash_index_unit fhi_checker u_fhi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

/* verif/fingerprint_hash_index_unit_test.sv */
// Self-checking testbench for fingerprint_hash_index_unit: lookups and inserts over
// several bucket counts, predicted by a bucket-queue model. Depends on fhi_pkg and the RTL.
module fingerprint_hash_index_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBuckets = 1024;
  localparam int unsigned BucketDepth = 64;
  localparam int unsigned CycleLimit = 2000000;

  localparam logic ActLookup = 1'b0;
  localparam logic ActInsert = 1'b1;

  typedef logic [3:0][63:0] key_t;

  typedef struct {
    logic        action;
    key_t        key;
    logic [63:0] addr;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] found_address;
    logic [9:0]  bucket_index;
  } result_t;

  typedef struct {
    key_t        key;
    logic [63:0] addr;
  } slot_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [10:0]  cfg_data_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [319:0] s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [79:0]  m_axis_tdata_o;

  fingerprint_hash_index_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Predictor state: bucket count register and the entries held by each bucket.
  logic [10:0] model_buckets;
  slot_t       bucket_slots[NumBuckets][$];

  request_t pending_requests[$];
  result_t  expected_results[$];
  key_t     inserted_keys[$];
  int unsigned fail_count;
  int unsigned cycle_count;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Computes the result of one request and updates the table contents.
  function automatic result_t hash_table_predict(request_t req);
    result_t     res;
    logic [63:0] folded;
    logic [63:0] modulus;
    int unsigned bucket;
    int unsigned fill;
    slot_t       entry;
    folded = req.key[0] ^ req.key[1] ^ req.key[2] ^ req.key[3];
    modulus = 64'(model_buckets);
    if (modulus == 0) modulus = 1;
    if (modulus > NumBuckets) modulus = NumBuckets;
    bucket = 32'(folded % modulus);
    fill = bucket_slots[bucket].size();
    res.status = fhi_pkg::StMiss;
    res.found_address = '0;
    res.bucket_index = bucket[9:0];
    if (req.action == ActLookup) begin
      for (int i = 0; i < fill; i++) begin
        if (bucket_slots[bucket][i].key == req.key) begin
          res.status = fhi_pkg::StOk;
          res.found_address = bucket_slots[bucket][i].addr;
          break;
        end
      end
    end else if (fill >= BucketDepth) begin
      res.status = fhi_pkg::StFull;
    end else begin
      entry.key = req.key;
      entry.addr = req.addr;
      bucket_slots[bucket].push_back(entry);
      res.status = fhi_pkg::StOk;
    end
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic key_t rand_key();
    key_t k;
    for (int w = 0; w < 4; w++) k[w] = rand_word();
    return k;
  endfunction

  task automatic queue_request(logic action, key_t key, logic [63:0] addr);
    request_t req;
    req.action = action;
    req.key = key;
    req.addr = addr;
    pending_requests.push_back(req);
    if (action == ActInsert) inserted_keys.push_back(key);
  endtask

  // Random traffic: mostly inserts and lookups of stored keys, some misses.
  task automatic queue_random(int unsigned count, int unsigned insert_weight);
    key_t        k;
    int unsigned pick;
    int unsigned bit_pos;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < insert_weight || inserted_keys.size() == 0) begin
        if ($urandom_range(0, 9) == 0 && inserted_keys.size() != 0)
          k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        else
          k = rand_key();
        queue_request(ActInsert, k, rand_word());
      end else begin
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        case ($urandom_range(0, 5))
          0: k = rand_key();
          1: begin
            // Same bucket, different fingerprint: flip one bit in two words.
            bit_pos = $urandom_range(0, 63);
            k[0][bit_pos] = ~k[0][bit_pos];
            k[3][bit_pos] = ~k[3][bit_pos];
          end
          default: ;
        endcase
        queue_request(ActLookup, k, rand_word());
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || expected_results.size() != 0 || s_axis_tvalid_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(logic [10:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_buckets = value;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i) begin
    logic    drive_valid;
    result_t res;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        res = hash_table_predict(pending_requests[0]);
        expected_results.push_back(res);
        void'(pending_requests.pop_front());
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      drive_valid = 1'b0;
      if (!(s_axis_tvalid_i && !s_axis_tready_o) && gap_left != 0) begin
        gap_left--;
      end else if (pending_requests.size() != 0) begin
        drive_valid = 1'b1;
      end
      s_axis_tvalid_i <= drive_valid;
      if (drive_valid) begin
        s_axis_tdata_i <= {pending_requests[0].addr, pending_requests[0].key};
        s_axis_tuser_i <= pending_requests[0].action;
      end
    end
  end

  // Result monitor with a rotating stall pattern, reloaded now and then.
  logic [7:0]  stall_pattern;
  int unsigned pattern_age;
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result 0x%h", m_axis_tdata_o);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (m_axis_tdata_o[1:0] != exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, m_axis_tdata_o[1:0]);
            fail_count++;
          end
          if (m_axis_tdata_o[65:2] != exp_res.found_address) begin
            $error("found_address: expected 0x%h, actual 0x%h",
                   exp_res.found_address, m_axis_tdata_o[65:2]);
            fail_count++;
          end
          if (m_axis_tdata_o[75:66] != exp_res.bucket_index) begin
            $error("bucket_index: expected %0d, actual %0d",
                   exp_res.bucket_index, m_axis_tdata_o[75:66]);
            fail_count++;
          end
        end
      end
      pattern_age++;
      if (pattern_age >= 48) begin
        pattern_age = 0;
        stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      end else begin
        stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      end
      m_axis_tready_i <= stall_pattern[0];
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus sequence: directed checks, then random phases over several bucket counts.
  initial begin
    key_t k;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    m_axis_tready_i = 1'b0;
    rst_ni = 1'b0;
    model_buckets = 11'd1024;
    fail_count = 0;
    cycle_count = 0;
    burst_left = 4;
    gap_left = 0;
    stall_pattern = 8'hff;
    pattern_age = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extreme keys and addresses, duplicates, near misses.
    queue_request(ActLookup, '0, '0);
    queue_request(ActInsert, '0, '0);
    queue_request(ActInsert, '1, '1);
    queue_request(ActLookup, '0, '1);
    queue_request(ActLookup, '1, '0);
    k = rand_key();
    queue_request(ActInsert, k, 64'h0123_4567_89ab_cdef);
    queue_request(ActInsert, k, 64'hfedc_ba98_7654_3210);
    queue_request(ActLookup, k, '0);
    k[1][5] = ~k[1][5];
    k[2][5] = ~k[2][5];
    queue_request(ActLookup, k, '0);
    wait_idle();

    // Single bucket: fill it past capacity, then scan deep.
    write_bucket_count(11'd1);
    queue_random(90, 85);
    queue_random(40, 10);
    wait_idle();
    // Zero acts as one: everything lands in the full bucket.
    write_bucket_count(11'd0);
    queue_random(40, 50);
    wait_idle();
    write_bucket_count(11'd2047);
    queue_random(75, 50);
    wait_idle();
    write_bucket_count(11'd3);
    queue_random(75, 60);
    wait_idle();
    write_bucket_count(11'd1024);
    queue_random(75, 50);
    wait_idle();
    write_bucket_count(11'd1000);
    queue_random(75, 50);
    wait_idle();
    write_bucket_count(11'd2);
    queue_random(75, 45);
    wait_idle();
    write_bucket_count(11'd1025);
    queue_random(80, 40);
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
